@@ sv/shtp_pkg.sv @@
// Shared types and constants for the SHTP packet deframer.
package shtp_pkg;

  localparam int unsigned LEN_W = 15;
  localparam int unsigned BYTE_W = 8;

  localparam logic [1:0] PH_PROBE = 2'd0;
  localparam logic [1:0] PH_ARMED = 2'd1;
  localparam logic [1:0] PH_FULL  = 2'd2;
  localparam logic [1:0] PH_IDLE  = 2'd3;

  localparam logic [LEN_W-1:0] HDR_BYTES     = 15'd4;
  localparam logic [LEN_W-1:0] PSEUDO_LEN    = 15'd8;
  localparam logic [BYTE_W-1:0] PSEUDO_CHAN_MAX = 8'd2;

  localparam logic [LEN_W-1:0]  MAX_LEN_RST    = 15'd1024;
  localparam logic [BYTE_W-1:0] CHAN_LIMIT_RST = 8'd6;

  localparam logic REG_MAX_LEN    = 1'b0;
  localparam logic REG_CHAN_LIMIT = 1'b1;

  typedef struct packed {
    logic              status;
    logic              has_data;
    logic              last;
    logic              cont;
    logic [BYTE_W-1:0] seq;
    logic [BYTE_W-1:0] chan;
    logic [BYTE_W-1:0] pbyte;
  } res_t;

  function automatic logic [LEN_W-1:0] field_length(input logic [BYTE_W-1:0] lo,
                                                    input logic [BYTE_W-1:0] hi);
    field_length = {hi[6:0], lo};
  endfunction

endpackage

@@ sv/shtp_packet_deframer.sv @@
// SHTP packet deframer: probe/full read header checks and payload word stream.
//
//  channel  dir  width  contents
//  s_axis   in   8+1    data byte, tuser = read_start
//  m_axis   out  32+2   payload/chan/seq/cont, tuser = has_data/status, tlast
//  apb      in   3/32   max_packet_length @0x0, channel_limit @0x4
//
// One input word per cycle while s_tready is high; each word is decoded in the
// accepting cycle and its result registered into the result or skid register.
// A two-entry output buffer (result register plus skid register) lets input
// flow while one result waits; s_tready drops only when both are full.
// Synchronous reset restores registers to 1024 and 6, phase to probe.
module shtp_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data
  input  logic        s_tuser,   // [0] read_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] payload_byte, [15:8] chan, [23:16] seq_number,
                                 // [24] continuation, [31:25] zero
  output logic [1:0]  m_tuser,   // [0] has_data, [1] status
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned LW = shtp_pkg::LEN_W;
  localparam int unsigned BW = shtp_pkg::BYTE_W;

  logic [LW-1:0] max_len;
  logic [BW-1:0] chan_limit;

  logic [1:0]    phase, phase_next;
  logic [LW-1:0] byte_count, byte_count_next;
  logic [LW-1:0] probed_length, probed_length_next;
  logic [BW-1:0] len_lo, len_lo_next;
  logic [BW-1:0] len_hi, len_hi_next;
  logic [BW-1:0] held_chan, held_chan_next;
  logic [BW-1:0] held_seq, held_seq_next;
  logic          held_cont, held_cont_next;
  logic [BW-1:0] first_pl, first_pl_next;
  logic [BW-1:0] second_pl, second_pl_next;

  logic              accept;
  logic              emit;
  shtp_pkg::res_t    res;
  shtp_pkg::res_t    out_q;
  shtp_pkg::res_t    skid_q;
  logic              skid_valid;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len    <= shtp_pkg::MAX_LEN_RST;
      chan_limit <= shtp_pkg::CHAN_LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == shtp_pkg::REG_MAX_LEN) begin
        max_len <= pwdata[LW-1:0];
      end else begin
        chan_limit <= pwdata[BW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == shtp_pkg::REG_CHAN_LIMIT) begin
      prdata = {{(32-BW){1'b0}}, chan_limit};
    end else begin
      prdata = {{(32-LW){1'b0}}, max_len};
    end
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // per-word decode
  always_comb begin
    logic [1:0]    ph;
    logic [LW-1:0] cnt;
    logic [LW-1:0] cnt1;
    logic [LW-1:0] len;
    logic [LW-1:0] pl_len;
    logic          len_ok;
    logic          pl_ok;

    phase_next         = phase;
    byte_count_next    = byte_count;
    probed_length_next = probed_length;
    len_lo_next        = len_lo;
    len_hi_next        = len_hi;
    held_chan_next     = held_chan;
    held_seq_next      = held_seq;
    held_cont_next     = held_cont;
    first_pl_next      = first_pl;
    second_pl_next     = second_pl;
    emit               = 1'b0;

    if (s_tuser) begin
      ph  = (phase == shtp_pkg::PH_ARMED) ? shtp_pkg::PH_FULL : shtp_pkg::PH_PROBE;
      cnt = '0;
    end else begin
      ph  = phase;
      cnt = byte_count;
    end
    cnt1 = cnt + 1'b1;
    phase_next      = ph;
    byte_count_next = cnt;

    if ((ph == shtp_pkg::PH_PROBE || ph == shtp_pkg::PH_FULL) && cnt < shtp_pkg::HDR_BYTES) begin
      case (cnt[1:0])
        2'd0:    len_lo_next = s_tdata;
        2'd1:    len_hi_next = s_tdata;
        2'd2:    held_chan_next = s_tdata;
        default: if (ph == shtp_pkg::PH_FULL) held_seq_next = s_tdata;
      endcase
      byte_count_next = cnt1;
    end

    len    = shtp_pkg::field_length(len_lo_next, len_hi_next);
    len_ok = (len >= shtp_pkg::HDR_BYTES) && (len <= max_len) && (held_chan_next < chan_limit);
    pl_len = shtp_pkg::field_length(first_pl_next, second_pl_next);
    pl_ok  = 1'b0;

    res.pbyte    = '0;
    res.has_data = 1'b0;
    res.chan     = held_chan;
    res.seq      = held_seq;
    res.cont     = held_cont;
    res.last     = 1'b1;
    res.status   = 1'b0;

    if (ph == shtp_pkg::PH_PROBE) begin
      if (cnt1 == shtp_pkg::HDR_BYTES) begin
        byte_count_next = '0;
        if (len_ok) begin
          probed_length_next = len;
          phase_next         = shtp_pkg::PH_ARMED;
        end else begin
          phase_next = shtp_pkg::PH_IDLE;
        end
      end
    end else if (ph == shtp_pkg::PH_FULL) begin
      if (cnt < shtp_pkg::HDR_BYTES) begin
        if (cnt1 == shtp_pkg::HDR_BYTES) begin
          held_cont_next = len_hi_next[7];
          if (!len_ok || len != probed_length ||
              (len_hi_next[7] && len == shtp_pkg::HDR_BYTES)) begin
            phase_next = shtp_pkg::PH_IDLE;
          end else if (len == shtp_pkg::HDR_BYTES) begin
            phase_next = shtp_pkg::PH_IDLE;
            emit       = 1'b1;
            res.chan   = held_chan_next;
            res.seq    = held_seq_next;
            res.cont   = held_cont_next;
          end
        end
      end else begin
        if (cnt == shtp_pkg::HDR_BYTES) begin
          first_pl_next = s_tdata;
        end else if (cnt == shtp_pkg::HDR_BYTES + 1'b1) begin
          second_pl_next = s_tdata;
        end
        byte_count_next = cnt1;
        pl_len          = shtp_pkg::field_length(first_pl_next, second_pl_next);
        emit            = 1'b1;
        res.pbyte       = s_tdata;
        res.has_data    = 1'b1;
        res.last        = (cnt1 >= probed_length);
        pl_ok           = (pl_len >= shtp_pkg::HDR_BYTES) && (pl_len <= max_len);
        if (res.last) begin
          phase_next = shtp_pkg::PH_IDLE;
          res.status = (probed_length == shtp_pkg::PSEUDO_LEN) &&
                       (held_chan <= shtp_pkg::PSEUDO_CHAN_MAX) && pl_ok;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= shtp_pkg::PH_PROBE;
      byte_count    <= '0;
      probed_length <= '0;
      len_lo        <= '0;
      len_hi        <= '0;
      held_chan     <= '0;
      held_seq      <= '0;
      held_cont     <= 1'b0;
      first_pl      <= '0;
      second_pl     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      probed_length <= probed_length_next;
      len_lo        <= len_lo_next;
      len_hi        <= len_hi_next;
      held_chan     <= held_chan_next;
      held_seq      <= held_seq_next;
      held_cont     <= held_cont_next;
      first_pl      <= first_pl_next;
      second_pl     <= second_pl_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept && emit;
      end
    end else if (accept && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (accept && emit) begin
      skid_q <= res;
    end
  end

  assign m_tdata = {7'd0, out_q.cont, out_q.seq, out_q.chan, out_q.pbyte};
  assign m_tuser = {out_q.status, out_q.has_data};
  assign m_tlast = out_q.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid full while output empty");

  a_armed_count: assert property (@(posedge clk) disable iff (rst)
    phase == shtp_pkg::PH_ARMED |-> byte_count == '0) else $error("armed with nonzero count");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1]) else $error("empty result not last");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast) else $error("status set on non-last result");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    phase == shtp_pkg::PH_FULL && byte_count > shtp_pkg::HDR_BYTES |->
      byte_count <= probed_length) else $error("payload count past packet length");

endmodule
